FILE: rtl/mpk_pkg.sv
// Shared types and constants for the k-transaction profit engine.
// No dependencies; every other file imports this package.
`default_nettype none

package mpk_pkg;

  // Widths fixed by the price and result formats.
  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 20;
  localparam int LIM_W    = 5;

  // Reset value of the transaction limit register.
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(2);

  // Largest value the result field can carry; larger profits saturate here.
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = '1;

  // Control bits that travel with each price through the chain of cells.
  typedef struct packed {
    logic valid;
    logic last;
  } cell_ctl_t;

endpackage : mpk_pkg

`default_nettype wire

FILE: rtl/mpk_if.sv
// Valid/ready channel interfaces for price items and profit results.
// Depends on mpk_pkg for the field widths.
`default_nettype none

interface mpk_price_if;
  import mpk_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               last_price;

  modport source (output valid, output price, output last_price, input ready);
  modport sink   (input valid, input price, input last_price, output ready);
endinterface : mpk_price_if

interface mpk_profit_if;
  import mpk_pkg::*;

  logic                valid;
  logic                ready;
  logic [PROFIT_W-1:0] max_profit;

  modport source (output valid, output max_profit, input ready);
  modport sink   (input valid, input max_profit, output ready);
endinterface : mpk_profit_if

`default_nettype wire

FILE: rtl/mpk_cell.sv
// One transaction level of the profit chain: holds best-holding and best-sold
// for its level and forwards the price and its new best-sold to the next level.
// Depends on mpk_pkg.
`default_nettype none

module mpk_cell #(
  parameter int LEVEL  = 1,
  parameter int SOLD_W = 20,
  parameter int IDX_W  = 5
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  mpk_pkg::cell_ctl_t           in_ctl,
  input  wire [mpk_pkg::PRICE_W-1:0]   in_price,
  input  wire [IDX_W-1:0]              in_lim,
  input  wire [mpk_pkg::PROFIT_W-1:0]  in_result,
  input  wire [SOLD_W-1:0]             in_sold,
  output mpk_pkg::cell_ctl_t           out_ctl,
  output logic [mpk_pkg::PRICE_W-1:0]  out_price,
  output logic [IDX_W-1:0]             out_lim,
  output logic [mpk_pkg::PROFIT_W-1:0] out_result,
  output logic [SOLD_W-1:0]            out_sold
);
  import mpk_pkg::*;

  localparam int HOLD_W = SOLD_W + 1;
  localparam int ARITH_W = SOLD_W + 2;
  localparam int CMP_W = (SOLD_W > PROFIT_W) ? SOLD_W : PROFIT_W;
  // Most negative holding value: below any reachable holding, so it acts as
  // "nothing bought yet at this level".
  localparam logic [HOLD_W-1:0] HOLD_RESET = {1'b1, {SOLD_W{1'b0}}};

  logic signed [HOLD_W-1:0]  hold_r, hold_nxt;
  logic        [SOLD_W-1:0]  sold_r, sold_nxt;
  cell_ctl_t                 ctl_r;
  logic [PRICE_W-1:0]        price_r;
  logic [IDX_W-1:0]          lim_r;
  logic [PROFIT_W-1:0]       result_r, result_nxt;
  logic [SOLD_W-1:0]         fwd_sold_r;

  logic signed [ARITH_W-1:0] price_a;
  logic signed [ARITH_W-1:0] buy_cand;
  logic signed [ARITH_W-1:0] hold_a;
  logic signed [ARITH_W-1:0] hold_new_a;
  logic signed [ARITH_W-1:0] sell_cand;
  logic signed [ARITH_W-1:0] sold_a;
  logic signed [ARITH_W-1:0] sold_new_a;
  logic [SOLD_W-1:0]         sold_new;
  logic [CMP_W-1:0]          sold_cmp;
  logic [PROFIT_W-1:0]       sold_sat;

  // Buy against the level below, then sell against the updated holding.
  always_comb begin
    price_a    = $signed({{(ARITH_W-PRICE_W){1'b0}}, in_price});
    buy_cand   = $signed({2'b00, in_sold}) - price_a;
    hold_a     = $signed({hold_r[HOLD_W-1], hold_r});
    hold_new_a = (buy_cand > hold_a) ? buy_cand : hold_a;
    sell_cand  = hold_new_a + price_a;
    sold_a     = $signed({2'b00, sold_r});
    sold_new_a = (sell_cand > sold_a) ? sell_cand : sold_a;
    sold_new   = sold_new_a[SOLD_W-1:0];
  end

  // Saturate this level's profit to the result range.
  always_comb begin
    sold_cmp = CMP_W'(sold_new);
    if (sold_cmp > CMP_W'(PROFIT_MAX)) begin
      sold_sat = PROFIT_MAX;
    end else begin
      sold_sat = PROFIT_W'(sold_cmp);
    end
  end

  // Level state: update on a valid price, clear after the series ends.
  always_comb begin
    hold_nxt   = hold_r;
    sold_nxt   = sold_r;
    result_nxt = in_result;
    if (in_ctl.valid) begin
      if (in_ctl.last) begin
        hold_nxt = HOLD_RESET;
        sold_nxt = '0;
        if (in_lim == IDX_W'(LEVEL)) begin
          result_nxt = sold_sat;
        end
      end else begin
        hold_nxt = hold_new_a[HOLD_W-1:0];
        sold_nxt = sold_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
      sold_r <= '0;
      ctl_r  <= '0;
    end else if (en) begin
      hold_r <= hold_nxt;
      sold_r <= sold_nxt;
      ctl_r  <= in_ctl;
    end
  end

  // Forwarded payload for the next level.
  always_ff @(posedge clk) begin
    if (en) begin
      price_r    <= in_price;
      lim_r      <= in_lim;
      result_r   <= result_nxt;
      fwd_sold_r <= sold_new;
    end
  end

  assign out_ctl    = ctl_r;
  assign out_price  = price_r;
  assign out_lim    = lim_r;
  assign out_result = result_r;
  assign out_sold   = fwd_sold_r;

endmodule : mpk_cell

`default_nettype wire

FILE: rtl/max_profit_k_transactions.sv
// Top level of the k-transaction profit engine: limit register, chain of
// level cells and output register. Depends on mpk_pkg, mpk_if and mpk_cell.
`default_nettype none

// Prices stream in on in_stream, one transfer per cycle while ready is high,
// with last_price marking the end of a series. A row of MAX_TX cells, one
// per transaction level, passes each price down the row one level per
// cycle, so a new price is taken every cycle while the output side keeps
// up. The profit for a series travels with its last price through the cell
// row into the output register and leaves on out_stream from there. A
// stalled output holds the whole row, and in_stream.ready drops with it.
// The limit written on cfg_wdata applies to series whose last price is
// transferred after the write; values above MAX_TX act as MAX_TX and zero
// yields a profit of zero.
module max_profit_k_transactions #(
  parameter int MAX_TX = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  mpk_price_if.sink                 in_stream,
  mpk_profit_if.source              out_stream,
  input  wire                       cfg_we,
  input  wire [mpk_pkg::LIM_W-1:0]  cfg_wdata
);
  import mpk_pkg::*;

  localparam int SOLD_W = $clog2(MAX_TX * 65535 + 1);
  localparam int IDX_W  = $clog2(MAX_TX + 1);
  localparam int LW     = (LIM_W > IDX_W) ? LIM_W : IDX_W;

  logic [LIM_W-1:0]    lim_r;
  logic [LW-1:0]       lim_ext;
  logic [IDX_W-1:0]    lim_idx;
  logic                en;
  logic                out_valid_r, out_valid_nxt;
  logic [PROFIT_W-1:0] out_profit_r;

  cell_ctl_t           link_ctl    [MAX_TX+1];
  logic [PRICE_W-1:0]  link_price  [MAX_TX+1];
  logic [IDX_W-1:0]    link_lim    [MAX_TX+1];
  logic [PROFIT_W-1:0] link_result [MAX_TX+1];
  logic [SOLD_W-1:0]   link_sold   [MAX_TX+1];

  // Transaction limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RESET;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  // Clamp the limit to the number of levels built.
  always_comb begin
    lim_ext = LW'(lim_r);
    if (lim_ext > LW'(MAX_TX)) begin
      lim_idx = IDX_W'(MAX_TX);
    end else begin
      lim_idx = IDX_W'(lim_ext);
    end
  end

  // The row advances whenever the output register is free or being drained.
  assign en              = !out_valid_r || out_stream.ready;
  assign in_stream.ready = en;

  // Head of the row: level zero holds no profit.
  always_comb begin
    link_ctl[0].valid = in_stream.valid;
    link_ctl[0].last  = in_stream.last_price;
    link_price[0]     = in_stream.price;
    link_lim[0]       = lim_idx;
    link_result[0]    = '0;
    link_sold[0]      = '0;
  end

  // One cell per transaction level.
  for (genvar g = 1; g <= MAX_TX; g++) begin : g_level
    mpk_cell #(
      .LEVEL  (g),
      .SOLD_W (SOLD_W),
      .IDX_W  (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_ctl     (link_ctl[g-1]),
      .in_price   (link_price[g-1]),
      .in_lim     (link_lim[g-1]),
      .in_result  (link_result[g-1]),
      .in_sold    (link_sold[g-1]),
      .out_ctl    (link_ctl[g]),
      .out_price  (link_price[g]),
      .out_lim    (link_lim[g]),
      .out_result (link_result[g]),
      .out_sold   (link_sold[g])
    );
  end

  // Output register: a last price leaving the row carries its profit.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = link_ctl[MAX_TX].valid && link_ctl[MAX_TX].last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && link_ctl[MAX_TX].valid && link_ctl[MAX_TX].last) begin
      out_profit_r <= link_result[MAX_TX];
    end
  end

  assign out_stream.valid      = out_valid_r;
  assign out_stream.max_profit = out_profit_r;

  // Pipeline payload of the row tail is only consumed through the result.
  logic unused_tail;
  assign unused_tail = ^{link_price[MAX_TX], link_lim[MAX_TX], link_sold[MAX_TX]};

endmodule : max_profit_k_transactions

`default_nettype wire

FILE: tb/tb_max_profit_k_transactions.sv
// Self-checking testbench for the k-transaction profit engine.
// Depends on mpk_pkg, mpk_if and max_profit_k_transactions from the RTL.
// Runs a directed table of price series, then random series under idle phases.
module tb_max_profit_k_transactions;
  import mpk_pkg::*;

  localparam int TX_LEVELS    = 16;
  localparam int DRAIN_CYCLES = TX_LEVELS + 8;
  localparam int TAIL_CYCLES  = 2 * TX_LEVELS + 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 155;
  localparam int SCRIPT_ROWS  = 22;

  // One row of the directed script; a limit write happens before the price.
  typedef struct packed {
    logic                do_cfg;
    logic [LIM_W-1:0]    cfg_val;
    logic [PRICE_W-1:0]  price;
    logic                last;
    logic                known;
    logic [PROFIT_W-1:0] profit;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  mpk_price_if  price_ch ();
  mpk_profit_if profit_ch ();

  max_profit_k_transactions #(
    .MAX_TX (TX_LEVELS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (price_ch),
    .out_stream (profit_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow of the transaction levels and of the limit register.
  logic signed [21:0] hold_lvl [1:TX_LEVELS];
  logic signed [21:0] sold_lvl [0:TX_LEVELS];
  logic [LIM_W-1:0]   limit_shadow;

  logic [PROFIT_W-1:0] profit_q [$];
  int errors;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;

  script_row_t script [0:SCRIPT_ROWS-1];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_levels();
    for (int j = 1; j <= TX_LEVELS; j++) begin
      hold_lvl[j] = -22'sd2097152;
    end
    for (int j = 0; j <= TX_LEVELS; j++) begin
      sold_lvl[j] = '0;
    end
  endfunction

  // Advance every level by one price; on the last price return the profit
  // at the current limit and start a fresh series.
  function automatic logic [PROFIT_W-1:0] advance_levels(input logic [PRICE_W-1:0] p,
                                                         input logic last);
    int cand;
    int lim;
    int best;
    cand = 0;
    best = 0;
    sold_lvl[0] = '0;
    for (int j = 1; j <= TX_LEVELS; j++) begin
      cand = int'(sold_lvl[j-1]) - int'(p);
      if (cand > int'(hold_lvl[j])) hold_lvl[j] = cand[21:0];
      cand = int'(hold_lvl[j]) + int'(p);
      if (cand > int'(sold_lvl[j])) sold_lvl[j] = cand[21:0];
    end
    if (last) begin
      lim = (int'(limit_shadow) > TX_LEVELS) ? TX_LEVELS : int'(limit_shadow);
      best = (lim == 0) ? 0 : int'(sold_lvl[lim]);
      if (best < 0) best = 0;
      if (best > int'(PROFIT_MAX)) best = int'(PROFIT_MAX);
      clear_levels();
    end
    return best[PROFIT_W-1:0];
  endfunction

  // Receiver side: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    profit_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each profit transfer with the oldest expectation.
  always @(negedge clk) begin : profit_check
    logic [PROFIT_W-1:0] want;
    if (rst_n && profit_ch.valid && profit_ch.ready) begin
      if (profit_q.size() == 0) begin
        $display("%0t: profit %0d arrived with none expected", $time,
                 profit_ch.max_profit);
        errors++;
      end else begin
        want = profit_q.pop_front();
        if (profit_ch.max_profit !== want) begin
          $display("%0t: max_profit expected %0d, got %0d", $time, want,
                   profit_ch.max_profit);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(negedge clk) begin
    if (!rst_n || (price_ch.valid && price_ch.ready) ||
        (profit_ch.valid && profit_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (profit_q.size() != 0) @(posedge clk);
  endtask

  // Write the limit with nothing in flight; the chain may still be working on
  // a series with no result pending, so let it settle first.
  task automatic write_limit(input logic [LIM_W-1:0] value);
    price_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    limit_shadow = value;
  endtask

  // Offer one price, wait for its transfer, then record what it should produce.
  task automatic send_price(input logic [PRICE_W-1:0] p, input logic last,
                            input logic known, input logic [PROFIT_W-1:0] typed);
    logic [PROFIT_W-1:0] predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      price_ch.valid <= 1'b0;
      @(posedge clk);
    end
    price_ch.valid      <= 1'b1;
    price_ch.price      <= p;
    price_ch.last_price <= last;
    @(negedge clk);
    while (!price_ch.ready) @(negedge clk);
    @(posedge clk);
    predicted = advance_levels(p, last);
    if (last) profit_q.push_back(known ? typed : predicted);
  endtask

  // One random series: mostly short, some long, some full swings between the
  // price extremes that come close to the top of the profit range.
  task automatic random_series(output int len);
    int shape;
    int style;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] p;
    shape = $urandom_range(99);
    style = $urandom_range(2);
    base  = PRICE_W'($urandom_range(0, 65520));
    p     = '0;
    if (shape < 75) len = $urandom_range(1, 12);
    else if (shape < 90) len = $urandom_range(13, 40);
    else len = $urandom_range(2, 34);
    for (int j = 0; j < len; j++) begin
      if (shape >= 90) begin
        p = j[0] ? 16'hFFFF : 16'h0000;
      end else begin
        case (style)
          0: p = PRICE_W'($urandom_range(0, 65535));
          1: p = base + PRICE_W'($urandom_range(0, 15));
          default: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
      end
      send_price(p, (j == len - 1), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [LIM_W-1:0] phase_limit [0:PHASES-1];
    int sent;
    int len;
    phase_limit = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2};
    sent = 0;
    len = 0;

    // Directed series: single price, limit extremes, saturation, mid-series change.
    script = '{
      '{1'b0, 5'd0,  16'd100,   1'b1, 1'b1, 20'd0},       // one price, reset limit
      '{1'b0, 5'd0,  16'd0,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd65535, 1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd0,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd65535, 1'b1, 1'b1, 20'd131070},  // two full swings
      '{1'b1, 5'd0,  16'd0,     1'b0, 1'b0, 20'd0},       // limit zero
      '{1'b0, 5'd0,  16'd65535, 1'b1, 1'b1, 20'd0},
      '{1'b1, 5'd31, 16'd10,    1'b0, 1'b0, 20'd0},       // limit saturates
      '{1'b0, 5'd0,  16'd20,    1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd5,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd30,    1'b1, 1'b0, 20'd0},
      '{1'b1, 5'd16, 16'd65535, 1'b0, 1'b0, 20'd0},       // falling prices
      '{1'b0, 5'd0,  16'd0,     1'b1, 1'b1, 20'd0},
      '{1'b1, 5'd1,  16'd5,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd1,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd9,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd3,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd12,    1'b1, 1'b0, 20'd0},
      '{1'b1, 5'd1,  16'd0,     1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd65535, 1'b0, 1'b0, 20'd0},
      '{1'b0, 5'd0,  16'd0,     1'b0, 1'b0, 20'd0},
      '{1'b1, 5'd3,  16'd65535, 1'b1, 1'b1, 20'd131070}   // limit raised mid-series
    };

    // Known values on every input before the first edge.
    errors              = 0;
    quiet_cycles        = 0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    price_ch.valid      = 1'b0;
    price_ch.price      = '0;
    price_ch.last_price = 1'b0;
    profit_ch.ready     = 1'b0;
    limit_shadow        = LIM_RESET;
    clear_levels();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].do_cfg) write_limit(script[r].cfg_val);
      send_price(script[r].price, script[r].last, script[r].known, script[r].profit);
    end

    // Random series, cycling through the idle patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
        default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      write_limit(phase_limit[ph]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_series(len);
        sent += len;
        // Now and then hold off until every profit has come back.
        if ($urandom_range(99) < 3) begin
          price_ch.valid <= 1'b0;
          wait_drained();
        end
      end
    end

    price_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
